>>> sv/rrt_pkg.sv
// Shared types and codes for the retry and rebroadcast table.
`default_nettype none
package rrt_pkg;

    localparam int MAX_RESULTS = 16;

    typedef enum logic [2:0] {
        CMD_ENQUEUE   = 3'd0,
        CMD_CONFIRM   = 3'd1,
        CMD_SCHEDULE  = 3'd2,
        CMD_KEY_TICK  = 3'd3,
        CMD_STAT_TICK = 3'd4,
        CMD_CLR_ALL   = 3'd5,
        CMD_CLR_KEY   = 3'd6,
        CMD_CLR_STAT  = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        RK_DONE    = 3'd0,
        RK_SEND    = 3'd1,
        RK_GAVE_UP = 3'd2,
        RK_SECURE  = 3'd3,
        RK_PLAIN   = 3'd4,
        RK_DROPPED = 3'd5
    } t_kind;

    localparam logic [1:0] REG_RETRY = 2'd0;
    localparam logic [1:0] REG_MAXR  = 2'd1;
    localparam logic [1:0] REG_RBC   = 2'd2;

    // One classified command handed from front to back.
    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] node;
        logic [31:0] key;
        logic [31:0] now;
        logic [7:0]  reps;
        logic [31:0] due;     // now + start_delay, precomputed
        logic        key_ok;  // psk & team & link
        logic        role_ok; // group & team & leader
        logic        link;
    } t_job;

endpackage : rrt_pkg
`default_nettype wire

>>> sv/retry_and_rebroadcast_table_top.sv
// Top level of the retry and rebroadcast table.
//
// Usage:
//  - Command channel: drive i_command and the payload with start; a word is
//    taken at an edge where start is high and busy is low. A two-entry
//    queue sits between the front end and the table engine; busy is high
//    while both entries are waiting.
//  - Result channel: each result word is shown for one cycle with o_done
//    high; o_last marks the final word of a command. The receiver cannot
//    stall, so results are never held back.
//  - APB port: retry_interval at 0x0, max_retries at 0x4,
//    rebroadcast_interval at 0x8; write only while idle.
// Timing: the engine visits one table entry per cycle and takes the next word
//  from the queue only when idle. Enqueue, confirm and key tick walk the key
//  table; a status tick walks the broadcast table and emits a secure and plain
//  pair per due entry; schedule, clears and gated ticks are a single action.
// Reset: synchronous, active low; empties both tables, the queue and sets
//  the registers to their defaults (30, 3, 10). No clearing pass is needed.
`default_nettype none
module retry_and_rebroadcast_table_top #(
    parameter int KEY_TABLE_DEPTH   = 16,
    parameter int BCAST_TABLE_DEPTH = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_command,
    input  wire logic [31:0] i_node_id,
    input  wire logic [31:0] i_key_id,
    input  wire logic [31:0] i_now_time,
    input  wire logic [7:0]  i_repeat_count,
    input  wire logic [31:0] i_start_delay,
    input  wire logic        i_has_psk,
    input  wire logic        i_has_team,
    input  wire logic        i_in_group,
    input  wire logic        i_is_leader,
    input  wire logic        i_link_ready,
    output logic             o_done,
    output logic [2:0]       o_result_kind,
    output logic [31:0]      o_out_node,
    output logic [31:0]      o_out_key,
    output logic [4:0]       o_key_jobs_pending,
    output logic [3:0]       o_status_jobs_pending,
    output logic             o_last
);
    logic [31:0] r_retry;
    logic [7:0]  r_maxr;
    logic [31:0] r_rbc;
    logic        job_valid, job_pop;
    rrt_pkg::t_job job;

    assign pready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry <= 32'd30;
            r_maxr  <= 8'd3;
            r_rbc   <= 32'd10;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                rrt_pkg::REG_RETRY: r_retry <= pwdata;
                rrt_pkg::REG_MAXR:  r_maxr  <= pwdata[7:0];
                rrt_pkg::REG_RBC:   r_rbc   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            rrt_pkg::REG_RETRY: prdata = r_retry;
            rrt_pkg::REG_MAXR:  prdata = {24'd0, r_maxr};
            rrt_pkg::REG_RBC:   prdata = r_rbc;
            default:            prdata = 32'd0;
        endcase
    end

    rrt_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_command, .i_node_id, .i_key_id,
        .i_now_time, .i_repeat_count, .i_start_delay, .i_has_psk, .i_has_team,
        .i_in_group, .i_is_leader, .i_link_ready, .o_busy(busy),
        .o_job_valid(job_valid), .o_job(job), .i_job_pop(job_pop)
    );

    rrt_back #(.KEY_DEPTH(KEY_TABLE_DEPTH), .BCAST_DEPTH(BCAST_TABLE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .i_job(job), .o_job_pop(job_pop),
        .i_retry_interval(r_retry), .i_max_retries(r_maxr),
        .i_rebroadcast_interval(r_rbc), .o_strobe(o_done), .o_result_kind,
        .o_out_node, .o_out_key, .o_key_jobs_pending, .o_status_jobs_pending, .o_last
    );

`ifndef SYNTHESIS
    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_done) else $error("last without strobe");
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr[3:2] == rrt_pkg::REG_MAXR)
        |=> r_maxr == $past(pwdata[7:0])) else $error("config write lost");
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result_kind <= 3'd5) else $error("bad result kind");
`endif
endmodule
`default_nettype wire

>>> sv/rrt_front.sv
// Front end: command capture, classification and a two-entry job queue.
`default_nettype none
module rrt_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [2:0]    i_command,
    input  wire logic [31:0]   i_node_id,
    input  wire logic [31:0]   i_key_id,
    input  wire logic [31:0]   i_now_time,
    input  wire logic [7:0]    i_repeat_count,
    input  wire logic [31:0]   i_start_delay,
    input  wire logic          i_has_psk,
    input  wire logic          i_has_team,
    input  wire logic          i_in_group,
    input  wire logic          i_is_leader,
    input  wire logic          i_link_ready,
    output logic               o_busy,
    output logic               o_job_valid,
    output rrt_pkg::t_job      o_job,
    input  wire logic          i_job_pop
);
    rrt_pkg::t_job r_q [2];
    logic [1:0]    r_cnt, n_cnt;
    logic          r_rd, r_wr;
    logic          push;
    rrt_pkg::t_job w;

    assign o_busy      = (r_cnt == 2'd2);
    assign push        = i_start && !o_busy;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd];

    always_comb begin
        w.cmd     = rrt_pkg::t_cmd'(i_command);
        w.node    = i_node_id;
        w.key     = i_key_id;
        w.now     = i_now_time;
        w.reps    = i_repeat_count;
        w.due     = i_now_time + i_start_delay;
        w.key_ok  = i_has_psk && i_has_team && i_link_ready;
        w.role_ok = i_in_group && i_has_team && i_is_leader;
        w.link    = i_link_ready;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, i_job_pop};
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= w;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wr <= !r_wr;
            if (i_job_pop) r_rd <= !r_rd;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_pop |-> o_job_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_job_pop) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("push lost");
`endif
endmodule
`default_nettype wire

>>> sv/rrt_back.sv
// Back end: walks the two tables one entry a cycle and emits results.
`default_nettype none
module rrt_back #(
    parameter int KEY_DEPTH   = 16,
    parameter int BCAST_DEPTH = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  rrt_pkg::t_job      i_job,
    output logic               o_job_pop,
    input  wire logic [31:0]   i_retry_interval,
    input  wire logic [7:0]    i_max_retries,
    input  wire logic [31:0]   i_rebroadcast_interval,
    output logic               o_strobe,
    output logic [2:0]         o_result_kind,
    output logic [31:0]        o_out_node,
    output logic [31:0]        o_out_key,
    output logic [4:0]         o_key_jobs_pending,
    output logic [3:0]         o_status_jobs_pending,
    output logic               o_last
);
    localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int BW = (BCAST_DEPTH > 1) ? $clog2(BCAST_DEPTH) : 1;
    localparam int KCW = $clog2(KEY_DEPTH + 1);
    localparam int BCW = $clog2(BCAST_DEPTH + 1);
    localparam int IW  = (KCW > BCW) ? KCW : BCW;   // walk index covers both tables

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_KEY  = 2'd1;
    localparam logic [1:0] S_BC   = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    // Tables kept as packed, ordered shift arrays.
    logic [31:0] r_knode  [KEY_DEPTH];
    logic [31:0] r_kident [KEY_DEPTH];
    logic [7:0]  r_katt   [KEY_DEPTH];
    logic [31:0] r_kdue   [KEY_DEPTH];
    logic [7:0]  r_bleft  [BCAST_DEPTH];
    logic [31:0] r_bdue   [BCAST_DEPTH];
    logic [KCW-1:0] r_kcnt;
    logic [BCW-1:0] r_bcnt;

    logic [1:0]     r_state;
    rrt_pkg::t_job  r_job;
    logic [IW-1:0]  r_idx;
    logic [4:0]     r_nres;   // results emitted so far for this command
    logic           r_pend_plain;

    logic [KW-1:0] ki;
    logic [BW-1:0] bi;
    logic          k_in, b_in, room_k, room_b;
    logic          k_due, b_due, k_match;
    logic [7:0]    bl_dec;

    assign ki      = r_idx[KW-1:0];
    assign bi      = r_idx[BW-1:0];
    assign k_in    = (r_idx < IW'(r_kcnt));
    assign b_in    = (r_idx < IW'(r_bcnt));
    assign room_k  = (r_nres < 5'(rrt_pkg::MAX_RESULTS));
    assign room_b  = (r_nres <= 5'(rrt_pkg::MAX_RESULTS - 2));
    assign k_due   = !(r_job.now < r_kdue[ki]);
    assign b_due   = !(r_job.now < r_bdue[bi]);
    assign k_match = (r_knode[ki] == r_job.node) && (r_kident[ki] == r_job.key);
    assign bl_dec  = (r_bleft[bi] != 8'd0) ? r_bleft[bi] - 8'd1 : 8'd0;

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    // Emit helper values set in the combinational block.
    logic           e_en, e_last;
    logic [2:0]     e_kind;
    logic [31:0]    e_node, e_key;
    logic [KCW-1:0] e_kc;
    logic [BCW-1:0] e_bc;
    // Table edit requests.
    logic           k_rm, k_upd, k_add, b_rm, b_upd, b_add, k_clr, b_clr;
    logic           dup_seen, r_dup;
    logic [1:0]     n_state;
    logic [IW-1:0]  n_idx;

    always_comb begin
        e_en = 1'b0; e_last = 1'b0; e_kind = rrt_pkg::RK_DONE;
        e_node = '0; e_key = '0; e_kc = r_kcnt; e_bc = r_bcnt;
        k_rm = 1'b0; k_upd = 1'b0; k_add = 1'b0; b_rm = 1'b0; b_upd = 1'b0;
        b_add = 1'b0; k_clr = 1'b0; b_clr = 1'b0; dup_seen = r_dup;
        n_state = r_state; n_idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_job_valid) n_state = S_KEY;
            end
            S_KEY: begin
                // Per-command walk over the key table, a single action, or entry to the broadcast walk.
                unique case (r_job.cmd)
                    rrt_pkg::CMD_ENQUEUE: begin
                        if (k_in) begin
                            if (k_match) dup_seen = 1'b1;
                            n_idx = r_idx + IW'(1);
                        end else begin
                            n_state = S_FIN;
                            if (!r_dup) begin
                                if (r_kcnt >= KCW'(KEY_DEPTH)) begin
                                    e_en = 1'b1; e_last = 1'b1;
                                    e_kind = rrt_pkg::RK_DROPPED;
                                    e_node = r_job.node; e_key = r_job.key;
                                end else begin
                                    k_add = 1'b1;
                                end
                            end
                        end
                    end
                    rrt_pkg::CMD_CONFIRM: begin
                        if (k_in) begin
                            if (k_match) k_rm = 1'b1;
                            else n_idx = r_idx + IW'(1);
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    rrt_pkg::CMD_SCHEDULE: begin
                        n_state = S_FIN;
                        if (r_job.reps != 8'd0) begin
                            if (r_bcnt >= BCW'(BCAST_DEPTH)) begin
                                e_en = 1'b1; e_last = 1'b1;
                                e_kind = rrt_pkg::RK_DROPPED;
                            end else begin
                                b_add = 1'b1;
                            end
                        end
                    end
                    rrt_pkg::CMD_KEY_TICK: begin
                        if (!r_job.key_ok || !k_in || !room_k) begin
                            n_state = S_FIN;
                        end else if (!k_due) begin
                            n_idx = r_idx + IW'(1);
                        end else begin
                            e_en = 1'b1;
                            e_node = r_knode[ki]; e_key = r_kident[ki];
                            if (r_katt[ki] >= i_max_retries) begin
                                k_rm = 1'b1; e_kind = rrt_pkg::RK_GAVE_UP;
                                e_kc = r_kcnt - KCW'(1);
                            end else begin
                                k_upd = 1'b1; e_kind = rrt_pkg::RK_SEND;
                                n_idx = r_idx + IW'(1);
                            end
                        end
                    end
                    rrt_pkg::CMD_STAT_TICK: begin
                        if (r_bcnt == '0) n_state = S_FIN;
                        else if (!r_job.role_ok) begin
                            b_clr = 1'b1; n_state = S_FIN;
                        end else if (!r_job.link) n_state = S_FIN;
                        else n_state = S_BC;
                    end
                    rrt_pkg::CMD_CLR_ALL: begin
                        k_clr = 1'b1; b_clr = 1'b1; n_state = S_FIN;
                    end
                    rrt_pkg::CMD_CLR_KEY: begin
                        k_clr = 1'b1; n_state = S_FIN;
                    end
                    default: begin
                        b_clr = 1'b1; n_state = S_FIN;
                    end
                endcase
            end
            S_BC: begin
                if (r_pend_plain) begin
                    // plain half of a pair: counts reflect the consumed repeat
                    e_en = 1'b1; e_kind = rrt_pkg::RK_PLAIN;
                end else if (!b_in || !room_b) begin
                    n_state = S_FIN;
                end else if (!b_due) begin
                    n_idx = r_idx + IW'(1);
                end else begin
                    e_en = 1'b1; e_kind = rrt_pkg::RK_SECURE;
                    if (bl_dec == 8'd0) b_rm = 1'b1;
                    else begin
                        b_upd = 1'b1; n_idx = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                if (r_nres == 5'd0) begin
                    e_en = 1'b1; e_last = 1'b1;
                end
            end
        endcase
        if (r_state == S_IDLE) dup_seen = 1'b0;
    end

    // Last flag of a walk: known only when the walk ends, so each result of a walk is
    // held in the r_h registers until the next result or the end, and the last one is marked when the end is found.
    logic           r_hold;
    logic [2:0]     r_hkind;
    logic [31:0]    r_hnode, r_hkey;
    logic [KCW-1:0] r_hkc;
    logic [BCW-1:0] r_hbc;
    logic           walk_end;

    assign walk_end = (r_state != S_IDLE) && (n_state == S_FIN || r_state == S_FIN);

    always_ff @(posedge i_clk) begin
        // output register
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
            o_last   <= 1'b0;
        end else if (r_hold && (e_en || walk_end)) begin
            o_strobe <= 1'b1;
            o_last   <= !e_en && walk_end;
            o_result_kind <= r_hkind; o_out_node <= r_hnode; o_out_key <= r_hkey;
            o_key_jobs_pending <= 5'(r_hkc); o_status_jobs_pending <= 4'(r_hbc);
        end else if (e_en && e_last) begin
            o_strobe <= 1'b1; o_last <= 1'b1;
            o_result_kind <= e_kind; o_out_node <= e_node; o_out_key <= e_key;
            o_key_jobs_pending <= 5'(e_kc); o_status_jobs_pending <= 4'(e_bc);
        end else begin
            o_strobe <= 1'b0;
            o_last   <= 1'b0;
        end
        if (e_en && !e_last) begin
            r_hkind <= e_kind; r_hnode <= e_node; r_hkey <= e_key;
            r_hkc <= e_kc; r_hbc <= e_bc;
        end

        if (r_state == S_IDLE && i_job_valid) r_job <= i_job;

        // key table edits
        if (k_add) begin
            r_knode[ki] <= r_job.node; r_kident[ki] <= r_job.key;
            r_katt[ki] <= 8'd0; r_kdue[ki] <= r_job.now + i_retry_interval;
        end
        if (k_upd) begin
            r_katt[ki] <= r_katt[ki] + 8'd1;
            r_kdue[ki] <= r_job.now + i_retry_interval;
        end
        if (k_rm) begin
            for (int j = 0; j < KEY_DEPTH - 1; j++) begin
                if (KW'(j) >= ki) begin
                    r_knode[j] <= r_knode[j+1]; r_kident[j] <= r_kident[j+1];
                    r_katt[j] <= r_katt[j+1]; r_kdue[j] <= r_kdue[j+1];
                end
            end
        end
        if (b_add) begin
            r_bleft[r_bcnt[BW-1:0]] <= r_job.reps;
            r_bdue[r_bcnt[BW-1:0]]  <= r_job.due;
        end
        if (b_upd) begin
            r_bleft[bi] <= bl_dec;
            r_bdue[bi]  <= r_job.now + i_rebroadcast_interval;
        end
        if (b_rm) begin
            for (int j = 0; j < BCAST_DEPTH - 1; j++) begin
                if (BW'(j) >= bi) begin
                    r_bleft[j] <= r_bleft[j+1]; r_bdue[j] <= r_bdue[j+1];
                end
            end
        end

        if (!i_rst_n) begin
            r_state <= S_IDLE; r_kcnt <= '0; r_bcnt <= '0; r_idx <= '0;
            r_nres <= '0; r_pend_plain <= 1'b0; r_hold <= 1'b0; r_dup <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_dup   <= dup_seen;
            if (k_clr) r_kcnt <= '0;
            else if (k_add) r_kcnt <= r_kcnt + KCW'(1);
            else if (k_rm) r_kcnt <= r_kcnt - KCW'(1);
            if (b_clr) r_bcnt <= '0;
            else if (b_add) r_bcnt <= r_bcnt + BCW'(1);
            else if (b_rm) r_bcnt <= r_bcnt - BCW'(1);
            if (r_state == S_IDLE) r_nres <= '0;
            else if (e_en) r_nres <= r_nres + 5'd1;
            if (r_state == S_BC) r_pend_plain <= e_en && !r_pend_plain;
            if (e_en && !e_last) r_hold <= 1'b1;
            else if (walk_end) r_hold <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_kcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kcnt <= KCW'(KEY_DEPTH)) else $error("key count overflow");
    a_bcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcnt <= BCW'(BCAST_DEPTH)) else $error("broadcast count overflow");
    a_plain_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BC && r_pend_plain) |-> e_en) else $error("unpaired status");
`endif
endmodule
`default_nettype wire

>>> verif/retry_and_rebroadcast_table_top_test.sv
// Self-checking testbench for the retry and rebroadcast table top level.
`timescale 1ns / 1ps
`default_nettype none
module retry_and_rebroadcast_table_top_test;

    localparam int KEY_DEPTH   = 16;
    localparam int BCAST_DEPTH = 8;
    localparam int SETTLE      = 40;   // key walk plus pipeline, with margin

    // One command word as driven on the input ports.
    typedef struct packed {
        rrt_pkg::t_cmd cmd;
        logic [31:0]   node;
        logic [31:0]   key;
        logic [31:0]   now;
        logic [7:0]    reps;
        logic [31:0]   delay;
        logic          psk;
        logic          team;
        logic          group;
        logic          leader;
        logic          link;
    } t_word;

    // One result word as seen on the output ports.
    typedef struct packed {
        rrt_pkg::t_kind kind;
        logic [31:0]    node;
        logic [31:0]    key;
        logic [4:0]     kpend;
        logic [3:0]     spend;
        logic           last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    t_word       drv = '0;
    logic        o_done;
    logic [2:0]  o_result_kind;
    logic [31:0] o_out_node, o_out_key;
    logic [4:0]  o_key_jobs_pending;
    logic [3:0]  o_status_jobs_pending;
    logic        o_last;

    retry_and_rebroadcast_table_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .i_command(drv.cmd), .i_node_id(drv.node), .i_key_id(drv.key),
        .i_now_time(drv.now), .i_repeat_count(drv.reps),
        .i_start_delay(drv.delay), .i_has_psk(drv.psk), .i_has_team(drv.team),
        .i_in_group(drv.group), .i_is_leader(drv.leader),
        .i_link_ready(drv.link),
        .o_done(o_done), .o_result_kind(o_result_kind), .o_out_node(o_out_node),
        .o_out_key(o_out_key), .o_key_jobs_pending(o_key_jobs_pending),
        .o_status_jobs_pending(o_status_jobs_pending), .o_last(o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Shadow of the block: registers and both ordered tables.
    // ---------------------------------------------------------------
    logic [31:0] sh_retry_ivl, sh_rbc_ivl;
    logic [7:0]  sh_max_retries;
    int          kt_count, bt_count;
    logic [31:0] kt_node[KEY_DEPTH], kt_key[KEY_DEPTH], kt_due[KEY_DEPTH];
    logic [7:0]  kt_tries[KEY_DEPTH];
    logic [7:0]  bt_left[BCAST_DEPTH];
    logic [31:0] bt_due[BCAST_DEPTH];

    t_word   pending_words[$];
    t_result expected_results[$];
    int      errors = 0;
    int      words_sent = 0, results_seen = 0, sends_seen = 0, giveups_seen = 0;
    int      secure_seen = 0, drops_seen = 0;
    bit      hold_sender = 1'b0;

    function automatic void shadow_reset();
        sh_retry_ivl = 32'd30;
        sh_max_retries = 8'd3;
        sh_rbc_ivl = 32'd10;
        kt_count = 0;
        bt_count = 0;
    endfunction

    function automatic void queue_word(t_word w);
        pending_words = {pending_words, w};
    endfunction

    function automatic void push_result(rrt_pkg::t_kind k, logic [31:0] nd,
                                        logic [31:0] ky);
        t_result r;
        r.kind = k;
        r.node = nd;
        r.key = ky;
        r.kpend = kt_count[4:0];
        r.spend = bt_count[3:0];
        r.last = 1'b0;
        expected_results = {expected_results, r};
    endfunction

    function automatic void key_drop(int idx);
        for (int j = idx; j + 1 < kt_count; j++) begin
            kt_node[j] = kt_node[j+1];
            kt_key[j] = kt_key[j+1];
            kt_tries[j] = kt_tries[j+1];
            kt_due[j] = kt_due[j+1];
        end
        kt_count--;
    endfunction

    function automatic void bcast_drop(int idx);
        for (int j = idx; j + 1 < bt_count; j++) begin
            bt_left[j] = bt_left[j+1];
            bt_due[j] = bt_due[j+1];
        end
        bt_count--;
    endfunction

    // Predicts every result word caused by one accepted command.
    function automatic void predict_results(t_word w);
        int n;
        int i;
        bit dup;
        n = 0;
        case (w.cmd)
            rrt_pkg::CMD_ENQUEUE: begin
                dup = 1'b0;
                for (i = 0; i < kt_count; i++)
                    if (kt_node[i] == w.node && kt_key[i] == w.key) dup = 1'b1;
                if (!dup) begin
                    if (kt_count >= KEY_DEPTH) begin
                        push_result(rrt_pkg::RK_DROPPED, w.node, w.key);
                        n++;
                    end else begin
                        kt_node[kt_count] = w.node;
                        kt_key[kt_count] = w.key;
                        kt_tries[kt_count] = 8'd0;
                        kt_due[kt_count] = w.now + sh_retry_ivl;
                        kt_count++;
                    end
                end
            end
            rrt_pkg::CMD_CONFIRM: begin
                i = 0;
                while (i < kt_count) begin
                    if (kt_node[i] == w.node && kt_key[i] == w.key) key_drop(i);
                    else i++;
                end
            end
            rrt_pkg::CMD_SCHEDULE: begin
                if (w.reps != 0) begin
                    if (bt_count >= BCAST_DEPTH) begin
                        push_result(rrt_pkg::RK_DROPPED, 32'd0, 32'd0);
                        n++;
                    end else begin
                        bt_left[bt_count] = w.reps;
                        bt_due[bt_count] = w.now + w.delay;
                        bt_count++;
                    end
                end
            end
            rrt_pkg::CMD_KEY_TICK: begin
                if (kt_count != 0 && w.psk && w.team && w.link) begin
                    i = 0;
                    while (i < kt_count && n < rrt_pkg::MAX_RESULTS) begin
                        if (w.now < kt_due[i]) begin
                            i++;
                        end else if (kt_tries[i] >= sh_max_retries) begin
                            logic [31:0] nd, ky;
                            nd = kt_node[i];
                            ky = kt_key[i];
                            key_drop(i);
                            push_result(rrt_pkg::RK_GAVE_UP, nd, ky);
                            n++;
                        end else begin
                            kt_tries[i] = kt_tries[i] + 8'd1;
                            kt_due[i] = w.now + sh_retry_ivl;
                            push_result(rrt_pkg::RK_SEND, kt_node[i], kt_key[i]);
                            n++;
                            i++;
                        end
                    end
                end
            end
            rrt_pkg::CMD_STAT_TICK: begin
                if (bt_count != 0) begin
                    if (!w.group || !w.team || !w.leader) begin
                        bt_count = 0;  // team role lost
                    end else if (w.link) begin
                        i = 0;
                        while (i < bt_count && n + 2 <= rrt_pkg::MAX_RESULTS) begin
                            if (w.now < bt_due[i]) begin
                                i++;
                            end else begin
                                push_result(rrt_pkg::RK_SECURE, 32'd0, 32'd0);
                                if (bt_left[i] > 0) bt_left[i]--;
                                if (bt_left[i] == 0) begin
                                    bcast_drop(i);
                                end else begin
                                    bt_due[i] = w.now + sh_rbc_ivl;
                                    i++;
                                end
                                push_result(rrt_pkg::RK_PLAIN, 32'd0, 32'd0);
                                n += 2;
                            end
                        end
                    end
                end
            end
            rrt_pkg::CMD_CLR_ALL: begin
                kt_count = 0;
                bt_count = 0;
            end
            rrt_pkg::CMD_CLR_KEY: kt_count = 0;
            default: bt_count = 0;
        endcase
        if (n == 0) push_result(rrt_pkg::RK_DONE, 32'd0, 32'd0);
        expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Driver: takes words from the pending queue, random gap per word.
    // ---------------------------------------------------------------
    int   gap_left = 0;
    logic busy_at_edge = 1'b1;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy_at_edge) begin
                // word was taken at the last rising edge
                if (pending_words.size() != 0 && gap_left == 0 && !hold_sender) begin
                    drv <= pending_words.pop_front();
                    gap_left <= $urandom_range(0, 13);
                end else begin
                    start <= 1'b0;
                end
            end else if (!start) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_words.size() != 0 && !hold_sender) begin
                    drv <= pending_words.pop_front();
                    start <= 1'b1;
                    gap_left <= $urandom_range(0, 13);
                end
            end
        end
    end

    // Acceptance is decided at the rising edge; the shadow predicts there.
    always @(posedge i_clk) begin
        busy_at_edge <= busy;
        if (i_rst_n && start && !busy) begin
            predict_results(drv);
            words_sent++;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: every strobed result word against the oldest expectation.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            t_result got, want;
            got.kind = rrt_pkg::t_kind'(o_result_kind);
            got.node = o_out_node;
            got.key = o_out_key;
            got.kpend = o_key_jobs_pending;
            got.spend = o_status_jobs_pending;
            got.last = o_last;
            results_seen++;
            if (got.kind == rrt_pkg::RK_SEND) sends_seen++;
            if (got.kind == rrt_pkg::RK_GAVE_UP) giveups_seen++;
            if (got.kind == rrt_pkg::RK_SECURE) secure_seen++;
            if (got.kind == rrt_pkg::RK_DROPPED) drops_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word: kind %0d node %h key %h",
                         $time, got.kind, got.node, got.key);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                    errors++;
                end
                if (got.node !== want.node) begin
                    $display("%0t: node expected %h actual %h", $time, want.node, got.node);
                    errors++;
                end
                if (got.key !== want.key) begin
                    $display("%0t: key expected %h actual %h", $time, want.key, got.key);
                    errors++;
                end
                if (got.kpend !== want.kpend) begin
                    $display("%0t: key pending expected %0d actual %0d",
                             $time, want.kpend, got.kpend);
                    errors++;
                end
                if (got.spend !== want.spend) begin
                    $display("%0t: status pending expected %0d actual %0d",
                             $time, want.spend, got.spend);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_word make_word(rrt_pkg::t_cmd c, logic [31:0] nd,
                                        logic [31:0] ky, logic [31:0] tnow);
        t_word w;
        w.cmd = c;
        w.node = nd;
        w.key = ky;
        w.now = tnow;
        w.reps = 8'($urandom_range(1, 4));
        w.delay = $urandom_range(0, 20);
        w.psk = 1'b1;
        w.team = 1'b1;
        w.group = 1'b1;
        w.leader = 1'b1;
        w.link = 1'b1;
        return w;
    endfunction

    task automatic wait_drained();
        while (pending_words.size() != 0 || start) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            rrt_pkg::REG_RETRY: sh_retry_ivl = val;
            rrt_pkg::REG_MAXR:  sh_max_retries = val[7:0];
            default:            sh_rbc_ivl = val;
        endcase
    endtask

    // Random phase: mostly meaningful traffic over a small id pool so that
    // duplicates, confirms, retries and give-ups happen; some noise.
    task automatic random_phase(int count, logic [31:0] t0);
        logic [31:0] tnow;
        t_word w;
        int sel;
        tnow = t0;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            tnow = tnow + $urandom_range(0, 12);
            if (sel < 30) w = make_word(rrt_pkg::CMD_ENQUEUE, $urandom_range(0, 5),
                                        $urandom_range(0, 3), tnow);
            else if (sel < 40) w = make_word(rrt_pkg::CMD_CONFIRM, $urandom_range(0, 5),
                                             $urandom_range(0, 3), tnow);
            else if (sel < 52) w = make_word(rrt_pkg::CMD_SCHEDULE, 0, 0, tnow);
            else if (sel < 72) w = make_word(rrt_pkg::CMD_KEY_TICK, 0, 0, tnow);
            else if (sel < 88) w = make_word(rrt_pkg::CMD_STAT_TICK, 0, 0, tnow);
            else begin
                // noise: any command, any field value
                w = make_word(rrt_pkg::t_cmd'($urandom_range(0, 7)), $urandom,
                              $urandom, $urandom);
                w.reps = 8'($urandom);
                w.delay = $urandom;
                {w.psk, w.team, w.group, w.leader, w.link} = 5'($urandom);
            end
            if ($urandom_range(0, 9) == 0)
                {w.psk, w.team, w.group, w.leader, w.link} = 5'($urandom);
            w.node = ($urandom_range(0, 7) == 0) ? $urandom : w.node;
            queue_word(w);
        end
    endtask

    initial begin
        t_word w;
        shadow_reset();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every command, dropped/full cases, gating, wrap.
        w = make_word(rrt_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        queue_word(w);                                   // due wraps past zero
        queue_word(w);                                   // duplicate, ignored
        queue_word(make_word(rrt_pkg::CMD_ENQUEUE, 0, 0, 0));
        w = make_word(rrt_pkg::CMD_KEY_TICK, 0, 0, 32'd100);
        w.psk = 1'b0;
        queue_word(w);                                   // gated off
        queue_word(make_word(rrt_pkg::CMD_KEY_TICK, 0, 0, 32'd100));
        queue_word(make_word(rrt_pkg::CMD_CONFIRM, 0, 0, 0));
        w = make_word(rrt_pkg::CMD_SCHEDULE, 0, 0, 32'hFFFF_FFFF);
        w.reps = 8'd0;
        queue_word(w);                                   // zero repeats
        w.reps = 8'd255;
        w.delay = 32'hFFFF_FFFF;
        queue_word(w);
        w = make_word(rrt_pkg::CMD_SCHEDULE, 0, 0, 0);
        w.reps = 8'd1;
        w.delay = 0;
        queue_word(w);
        w = make_word(rrt_pkg::CMD_STAT_TICK, 0, 0, 32'd5);
        w.link = 1'b0;
        queue_word(w);                                   // link down, nothing
        queue_word(make_word(rrt_pkg::CMD_STAT_TICK, 0, 0, 32'hFFFF_FFFE));
        w = make_word(rrt_pkg::CMD_STAT_TICK, 0, 0, 32'd5);
        w.leader = 1'b0;
        queue_word(w);                                   // role lost, table cleared
        for (int k = 0; k < 17; k++)                     // fill key table, two drops
            queue_word(make_word(rrt_pkg::CMD_ENQUEUE, k, 32'hA5A5_0000 + k, 0));
        wait_drained();
        for (int k = 0; k < 9; k++)                      // fill broadcast table
            queue_word(make_word(rrt_pkg::CMD_SCHEDULE, 0, 0, 0));
        for (int k = 0; k < 5; k++)                      // tick until all give up
            queue_word(make_word(rrt_pkg::CMD_KEY_TICK, 0, 0, 32'd1000 * (k + 1)));
        queue_word(make_word(rrt_pkg::CMD_STAT_TICK, 0, 0, 32'd50));
        queue_word(make_word(rrt_pkg::CMD_CLR_KEY, 0, 0, 0));
        queue_word(make_word(rrt_pkg::CMD_CLR_STAT, 0, 0, 0));
        queue_word(make_word(rrt_pkg::CMD_CLR_ALL, 0, 0, 0));

        // Sender pauses mid-stream until every expected result is home.
        repeat (30) @(posedge i_clk);
        hold_sender = 1'b1;
        while (start || expected_results.size() != 0) @(posedge i_clk);
        hold_sender = 1'b0;
        wait_drained();

        reg_write(rrt_pkg::REG_RETRY, 32'd0);
        reg_write(rrt_pkg::REG_MAXR, 32'd0);
        reg_write(rrt_pkg::REG_RBC, 32'd0);
        random_phase(30, 32'd0);
        wait_drained();

        reg_write(rrt_pkg::REG_RETRY, 32'hFFFF_FFFF);
        reg_write(rrt_pkg::REG_MAXR, 32'd255);
        reg_write(rrt_pkg::REG_RBC, 32'hFFFF_FFFF);
        random_phase(20, 32'hFFFF_FF00);
        wait_drained();

        reg_write(rrt_pkg::REG_RETRY, 32'd7);
        reg_write(rrt_pkg::REG_MAXR, 32'd2);
        reg_write(rrt_pkg::REG_RBC, 32'd5);
        random_phase(55, 32'd500);
        wait_drained();

        $display("covered %0d commands, %0d result words: %0d sends, %0d give-ups,",
                 words_sent, results_seen, sends_seen, giveups_seen);
        $display("  %0d status pairs, %0d drops; three register settings incl. extremes",
                 secure_seen, drops_seen);
        if (errors == 0) begin
            $display("retry_and_rebroadcast_table_top verification clean");
        end else begin
            $display("retry_and_rebroadcast_table_top verification failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("retry_and_rebroadcast_table_top verification failed");
        $finish;
    end

endmodule
`default_nettype wire
